// ----- rtl/stq_pkg.sv -----
`default_nettype none
package stq_pkg;
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CANCEL = 2'd1,
		OP_CHECK  = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EXPIRED   = 3'd4,
		ST_NONE      = 3'd5
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_NORM  = 2'd1,
		S_EXEC  = 2'd2,
		S_SHIFT = 2'd3
	} state_t;

	localparam int TotalW = 37;
	localparam logic [19:0] MinTimeoutReset = 20'd100000;
	localparam logic [19:0] UsPerSec = 20'd1000000;
	localparam logic [9:0] UsPerMs = 10'd1000;

	// one queue entry
	typedef struct packed {
		logic              valid;
		logic [15:0]       session;
		logic [31:0]       start_ms;
		logic [TotalW-1:0] timeout_us;
	} entry_t;

	// broadcast command to every cell
	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [15:0]       session;
		logic [31:0]       clock_ms;
		logic [TotalW-1:0] total_us;
	} bcast_t;

	// per-cell status seen by the controller
	typedef struct packed {
		logic valid;
		logic ahead;    // new entry goes ahead of this one
		logic match;    // session matches
		logic expired;
	} cell_flags_t;
endpackage
`default_nettype wire

// ----- rtl/stq_norm.sv -----
`default_nettype none
// Converts sec/usec into a microsecond total. Carrying whole seconds out of
// usec leaves sec * 10^6 + usec unchanged, so one scale and one add suffice.
// The total and the done strobe are ready in the cycle after start.
module stq_norm (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [15:0]               sec,
	input  wire logic [31:0]               usec,
	output logic                           done,
	output logic [stq_pkg::TotalW-1:0]     total
);
	import stq_pkg::*;

	logic [35:0] sec_us_q;
	logic [31:0] usec_q;

	assign total = {1'b0, sec_us_q} + {5'd0, usec_q};

	// done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= start;
		end
	end

	// seconds scaled to microseconds
	always_ff @(posedge clk) begin
		if (start) begin
			sec_us_q <= sec * 36'(UsPerSec);
			usec_q   <= usec;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/stq_cell.sv -----
`default_nettype none
// One queue slot. Takes the new entry at the insert point, shifts right after
// it on insert, and shifts left at or after the removal point on removal.
module stq_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stq_pkg::bcast_t      bc,
	input  wire logic                 ins_here,    // insert point is this slot
	input  wire logic                 ins_shift,   // take left neighbor
	input  wire logic                 rem_shift,   // take right neighbor
	input  wire stq_pkg::entry_t      left_in,
	input  wire stq_pkg::entry_t      right_in,
	output stq_pkg::entry_t           ent,
	output stq_pkg::cell_flags_t      flags
);
	import stq_pkg::*;

	logic              valid_q;
	logic [15:0]       session_q;
	logic [31:0]       start_q;
	logic [TotalW-1:0] timeout_q;
	logic [31:0]       elapsed;
	logic [41:0]       el_us;
	logic [42:0]       el_sum;

	assign ent     = {valid_q, session_q, start_q, timeout_q};
	assign elapsed = bc.clock_ms - start_q;
	assign el_us   = elapsed * 42'(UsPerMs);
	// one extra bit so the sum cannot wrap
	assign el_sum  = {1'b0, el_us} + {6'd0, bc.total_us};

	always_comb begin
		flags.valid   = valid_q;
		flags.match   = valid_q && (session_q == bc.session);
		flags.expired = valid_q && (el_us >= {5'd0, timeout_q});
		flags.ahead   = valid_q && (el_sum < {6'd0, timeout_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (bc.cmd)
				CMD_INSERT: begin
					if (ins_here) valid_q <= 1'b1;
					else if (ins_shift) valid_q <= left_in.valid;
				end
				CMD_REMOVE: if (rem_shift) valid_q <= right_in.valid;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (bc.cmd)
			CMD_INSERT: begin
				if (ins_here) begin
					session_q <= bc.session;
					start_q   <= bc.clock_ms;
					timeout_q <= bc.total_us;
				end else if (ins_shift) begin
					session_q <= left_in.session;
					start_q   <= left_in.start_ms;
					timeout_q <= left_in.timeout_us;
				end
			end
			CMD_REMOVE: if (rem_shift) begin
				session_q <= right_in.session;
				start_q   <= right_in.start_ms;
				timeout_q <= right_in.timeout_us;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/sorted_timeout_queue.sv -----
`default_nettype none
// Deadline-ordered session timer queue built as a row of QUEUE_DEPTH slot cells.
// Each request first advances the millisecond clock, then inserts, cancels,
// checks or queries. Insert scales the seconds to microseconds in stq_norm,
// latches the total in S_NORM and registers its result in S_EXEC, where the
// cell row takes the new entry; cancel and query register theirs in S_EXEC,
// and a successful cancel then shifts the row in S_SHIFT. Check emits an
// expired result in S_EXEC, then shifts the row in S_SHIFT, for each expired
// entry while the receiver keeps up, or a single none-expired result. Results
// wait in an output register, and a new request is taken once all results of
// the current one have been sent.
module sorted_timeout_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [19:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] session_id,
	input  wire logic [15:0] timeout_sec,
	input  wire logic [31:0] timeout_usec,
	input  wire logic [15:0] time_advance_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      result_session,
	output logic [31:0]      elapsed_ms,
	output logic             last
);
	import stq_pkg::*;

	localparam int IdxW = $clog2(QUEUE_DEPTH);

	state_t      state_q, state_d;
	logic [19:0] min_q;
	logic [31:0] clock_q;
	op_t         op_q;
	logic [15:0] sess_q;
	logic [TotalW-1:0] total_q;
	logic        norm_start, norm_done;
	logic [TotalW-1:0] norm_total;

	bcast_t      bc;
	entry_t      ents  [QUEUE_DEPTH];
	cell_flags_t flg   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] ahead_v, match_v, valid_v;
	logic [QUEUE_DEPTH-1:0] ins_here, ins_shift, rem_shift;
	logic [QUEUE_DEPTH-1:0] ins_pre, rem_pre;
	logic        rem_pos_we;
	logic [IdxW-1:0] rem_pos_q;
	logic        full;
	entry_t      null_ent;

	// output register
	logic        emit;
	logic [2:0]  st_d;
	logic [15:0] rs_d;
	logic [31:0] el_d;
	logic        last_d;
	logic [31:0] el_match;

	assign null_ent   = '0;
	assign in_ready   = (state_q == S_IDLE) && !out_valid;
	assign full       = valid_v[QUEUE_DEPTH-1];
	assign norm_start = in_valid && in_ready && (op_t'(operation) == OP_INSERT);

	stq_norm u_norm (
		.clk, .arst_n, .start(norm_start), .sec(timeout_sec), .usec(timeout_usec),
		.done(norm_done), .total(norm_total)
	);

	// cell row
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		stq_cell u_cell (
			.clk, .arst_n, .bc,
			.ins_here(ins_here[g]), .ins_shift(ins_shift[g]), .rem_shift(rem_shift[g]),
			.left_in(g == 0 ? null_ent : ents[(g == 0) ? 0 : g-1]),
			.right_in(g == QUEUE_DEPTH-1 ? null_ent : ents[(g == QUEUE_DEPTH-1) ? g : g+1]),
			.ent(ents[g]), .flags(flg[g])
		);
		assign ahead_v[g] = flg[g].ahead;
		assign match_v[g] = flg[g].match;
		assign valid_v[g] = flg[g].valid;
	end

	// insert point: first slot that is empty or whose deadline is later
	always_comb begin
		ins_pre[0] = 1'b0;
		for (int i = 1; i < QUEUE_DEPTH; i++)
			ins_pre[i] = ins_pre[i-1] || ahead_v[i-1] || !valid_v[i-1];
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ins_here[i]  = !ins_pre[i] && (ahead_v[i] || !valid_v[i]);
			ins_shift[i] = ins_pre[i];
		end
		for (int i = 0; i < QUEUE_DEPTH; i++)
			rem_pre[i] = (IdxW'(i) >= rem_pos_q);
		rem_shift = rem_pre;
	end

	// first matching session
	always_comb begin
		el_match = '0;
		for (int i = QUEUE_DEPTH-1; i >= 0; i--)
			if (match_v[i]) el_match = clock_q - ents[i].start_ms;
	end

	logic            any_match;
	logic [IdxW-1:0] match_idx;
	always_comb begin
		match_idx = '0;
		for (int i = QUEUE_DEPTH-1; i >= 0; i--)
			if (match_v[i]) match_idx = IdxW'(i);
	end
	assign any_match = |match_v;

	always_comb begin
		bc.session  = sess_q;
		bc.clock_ms = clock_q;
		bc.total_us = total_q;
		bc.cmd      = CMD_HOLD;
		state_d     = state_q;
		emit        = 1'b0;
		st_d        = ST_OK;
		rs_d        = sess_q;
		el_d        = '0;
		last_d      = 1'b1;
		rem_pos_we  = 1'b0;
		case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				if (op_t'(operation) == OP_INSERT) begin
					state_d = S_NORM;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_NORM: if (norm_done) begin
				state_d = S_EXEC;
			end
			S_EXEC: if (!out_valid || out_ready) begin
				case (op_q)
					OP_INSERT: begin
						emit    = 1'b1;
						state_d = S_IDLE;
						if (total_q < {17'd0, min_q}) st_d = ST_INVALID;
						else if (full) st_d = ST_FULL;
						else bc.cmd = CMD_INSERT;
					end
					OP_CANCEL: begin
						emit = 1'b1;
						if (any_match) begin
							rem_pos_we = 1'b1;
							state_d = S_SHIFT;
						end else begin
							st_d = ST_NOT_FOUND;
							state_d = S_IDLE;
						end
					end
					OP_QUERY: begin
						emit    = 1'b1;
						state_d = S_IDLE;
						if (any_match) el_d = el_match;
						else st_d = ST_NOT_FOUND;
					end
					default: begin
						// the clock holds during a burst, so slot 1 tells whether
						// another entry expires once the head is removed
						if (flg[0].expired) begin
							emit       = 1'b1;
							st_d       = ST_EXPIRED;
							rs_d       = ents[0].session;
							last_d     = !flg[1].expired;
							rem_pos_we = 1'b1;
							state_d    = S_SHIFT;
						end else begin
							emit    = 1'b1;
							st_d    = ST_NONE;
							rs_d    = '0;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_SHIFT: begin
				bc.cmd  = CMD_REMOVE;
				state_d = (op_q == OP_CHECK && flg[1].expired) ? S_EXEC : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			min_q     <= MinTimeoutReset;
			clock_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) min_q <= cfg_wdata;
			if (in_valid && in_ready) clock_q <= clock_q + {16'd0, time_advance_ms};
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= op_t'(operation);
			sess_q <= session_id;
		end
		if (norm_done) total_q <= norm_total;
		if (rem_pos_we) rem_pos_q <= (op_q == OP_CHECK) ? '0 : match_idx;
		if (emit) begin
			status         <= st_d;
			result_session <= rs_d;
			elapsed_ms     <= el_d;
			last           <= last_d;
		end
	end
endmodule
`default_nettype wire
